// File: rtl/pidrl_pkg.sv
package pidrl_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned GAIN_W    = 31;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_OUT_LIMIT = 3'd3,
        REG_RAMP_RATE = 3'd4
    } cfg_reg_t;

    localparam logic [GAIN_W-1:0] RST_GAIN_P    = 31'd1966;
    localparam logic [GAIN_W-1:0] RST_GAIN_I    = 31'd65536;
    localparam logic [GAIN_W-1:0] RST_GAIN_D    = 31'd0;
    localparam logic [GAIN_W-1:0] RST_OUT_LIMIT = 31'd262144;
    localparam logic [GAIN_W-1:0] RST_RAMP_RATE = 31'd6553600;

    localparam int unsigned DT_W = 19;
    localparam logic [DATA_W-1:0] DT_MAX_US     = 32'd500000;
    localparam logic [DT_W-1:0]   DT_DEFAULT_US = 19'd1000;
    localparam logic [DATA_W-1:0] US_PER_S      = 32'd1000000;

    localparam int unsigned DIV_NUM_W = 52;
    localparam int unsigned DIV_DEN_W = 20;
    localparam int unsigned DIV_STEPS = DIV_NUM_W / 2;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // Saturates a 34-bit signed value to the 32-bit signed range.
    function automatic logic signed [DATA_W-1:0] sat34(input logic signed [33:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < 34'sh3_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // Clamps a 34-bit signed value to plus or minus a 31-bit limit.
    function automatic logic signed [DATA_W-1:0] clamp34(input logic signed [33:0] v,
                                                         input logic [GAIN_W-1:0] lim);
        logic signed [33:0] pos;
        logic signed [33:0] r;
        pos = signed'({3'b000, lim});
        if (v > pos) begin
            r = pos;
        end else if (v < -pos) begin
            r = -pos;
        end else begin
            r = v;
        end
        return r[DATA_W-1:0];
    endfunction

    // Divides a Q16.16 product by 65536 toward zero and saturates to 32 bits.
    function automatic logic signed [DATA_W-1:0] q16_sat(input logic signed [63:0] prod);
        logic signed [63:0] adj;
        logic signed [47:0] q;
        logic signed [DATA_W-1:0] r;
        adj = prod[63] ? prod + 64'sd65535 : prod;
        q   = adj[63:16];
        if (q > 48'sh0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (q < 48'shFFFF_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = q[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/pid_with_ramp_limit.sv
// PID controller with a Tustin integral, a derivative over the measured sample
// period and a slew-limited output, all in signed Q16.16. One shared 32x32
// multiplier and one radix-4 restoring divider do the arithmetic under a small
// sequencer: a control request runs through the multiplier states for the P, I,
// D, dt and 1000000 products, then three divisions (two by 1000000 and one by the
// sample period), then the sum, ramp-limit and store states. A clear request goes
// straight to the store state with a zero result.
// The input side is ready only while the sequencer is idle; a finished result
// waits in the output register while the next request is taken.
module pid_with_ramp_limit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // error [31:0], timestamp_us [63:32]
    input  logic [0:0]  s_tuser,   // op [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // drive [31:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [pidrl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data
);
    import pidrl_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_P, ST_MUL_I, ST_MUL_D, ST_MUL_DT, ST_MUL_US,
        ST_DIV1, ST_DIV2, ST_DIV3, ST_SUM, ST_RAMP, ST_DONE
    } state_t;

    state_t state_reg;

    logic [GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg, out_limit_reg, ramp_rate_reg;

    logic signed [DATA_W-1:0] integral_acc_reg, last_output_reg, last_error_reg;
    logic [DATA_W-1:0]        last_time_reg;

    logic signed [DATA_W-1:0] e_reg, avg_reg, diff_reg;
    logic [DATA_W-1:0]        now_reg;
    logic [DT_W-1:0]          dt_reg;
    logic signed [DATA_W-1:0] p_reg, m_reg, dm_reg, inc_reg, integ_reg, d_reg;
    logic signed [DATA_W-1:0] sum_reg, res_reg;
    logic [GAIN_W-1:0]        step_reg;
    logic                     clr_reg;
    logic                     m_valid_reg;
    logic [DATA_W-1:0]        m_data_reg;

    logic                        in_accept;
    logic signed [DATA_W-1:0]    in_error;
    logic [DATA_W-1:0]           in_time;
    logic [DATA_W-1:0]           dt_raw;
    logic [DT_W-1:0]             dt_sel;
    logic signed [DATA_W:0]      pair_sum, pair_adj;
    logic signed [DATA_W:0]      err_diff;

    logic                        mul_en;
    logic signed [DATA_W-1:0]    mul_a, mul_b;
    logic signed [2*DATA_W-1:0]  prod;
    logic                        div_start, div_busy, div_done;
    logic [DIV_DEN_W-1:0]        div_den;
    logic signed [DATA_W-1:0]    div_q;

    logic signed [33:0]          prev34, drv34, delta34, step34, ramp34;
    logic                        res_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_error  = signed'(s_tdata[31:0]);
    assign in_time   = s_tdata[63:32];
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign cfg_ready = 1'b1;
    assign res_free  = !m_valid_reg || m_tready;

    assign dt_raw = in_time - last_time_reg;
    assign dt_sel = (dt_raw == '0 || dt_raw > DT_MAX_US) ? DT_DEFAULT_US : dt_raw[DT_W-1:0];

    assign pair_sum = 33'(in_error) + 33'(last_error_reg);
    assign pair_adj = (pair_sum[DATA_W] && pair_sum[0]) ? pair_sum + 33'sd1 : pair_sum;
    assign err_diff = 33'(in_error) - 33'(last_error_reg);

    always_comb begin
        mul_en = 1'b1;
        mul_a  = signed'({1'b0, gain_p_reg});
        mul_b  = e_reg;
        unique case (state_reg)
            ST_MUL_P: begin
                mul_a = signed'({1'b0, gain_p_reg});
                mul_b = e_reg;
            end
            ST_MUL_I: begin
                mul_a = signed'({1'b0, gain_i_reg});
                mul_b = avg_reg;
            end
            ST_MUL_D: begin
                mul_a = signed'({1'b0, gain_d_reg});
                mul_b = diff_reg;
            end
            ST_MUL_DT: begin
                mul_a = m_reg;
                mul_b = signed'(DATA_W'(dt_reg));
            end
            ST_MUL_US: begin
                mul_a = dm_reg;
                mul_b = signed'(US_PER_S);
            end
            ST_DIV1: begin
                mul_en = div_done;
                mul_a  = signed'({1'b0, ramp_rate_reg});
                mul_b  = signed'(DATA_W'(dt_reg));
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign div_start = (state_reg == ST_MUL_US) ||
                       ((state_reg == ST_DIV1 || state_reg == ST_DIV2) && div_done);
    assign div_den   = (state_reg == ST_DIV1) ? DIV_DEN_W'(dt_reg) : US_PER_S[DIV_DEN_W-1:0];

    pidrl_mul u_mul (
        .aclk     (aclk),
        .en       (mul_en),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    pidrl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod),
        .divisor  (div_den),
        .busy_reg (div_busy),
        .done_reg (div_done),
        .quotient (div_q)
    );

    always_comb begin
        prev34  = 34'(last_output_reg);
        drv34   = 34'(sum_reg);
        delta34 = drv34 - prev34;
        step34  = signed'({3'b000, step_reg});
        ramp34  = drv34;
        if (ramp_rate_reg != '0) begin
            if (delta34 > step34) begin
                ramp34 = prev34 + step34;
            end else if (delta34 < -step34) begin
                ramp34 = prev34 - step34;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg    <= RST_GAIN_P;
            gain_i_reg    <= RST_GAIN_I;
            gain_d_reg    <= RST_GAIN_D;
            out_limit_reg <= RST_OUT_LIMIT;
            ramp_rate_reg <= RST_RAMP_RATE;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_GAIN_P:    gain_p_reg    <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:    gain_i_reg    <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:    gain_d_reg    <= cfg_data[GAIN_W-1:0];
                REG_OUT_LIMIT: out_limit_reg <= cfg_data[GAIN_W-1:0];
                REG_RAMP_RATE: ramp_rate_reg <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            integral_acc_reg <= '0;
            last_output_reg  <= '0;
            last_error_reg   <= '0;
            last_time_reg    <= '0;
        end else begin
            if (m_valid_reg && m_tready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        if (s_tuser[0]) begin
                            clr_reg   <= 1'b1;
                            res_reg   <= '0;
                            state_reg <= ST_DONE;
                        end else begin
                            clr_reg   <= 1'b0;
                            e_reg     <= in_error;
                            now_reg   <= in_time;
                            dt_reg    <= dt_sel;
                            avg_reg   <= pair_adj[DATA_W:1];
                            diff_reg  <= sat34(34'(err_diff));
                            state_reg <= ST_MUL_P;
                        end
                    end
                end
                ST_MUL_P: state_reg <= ST_MUL_I;
                ST_MUL_I: begin
                    p_reg     <= q16_sat(prod);
                    state_reg <= ST_MUL_D;
                end
                ST_MUL_D: begin
                    m_reg     <= q16_sat(prod);
                    state_reg <= ST_MUL_DT;
                end
                ST_MUL_DT: begin
                    dm_reg    <= q16_sat(prod);
                    state_reg <= ST_MUL_US;
                end
                ST_MUL_US: state_reg <= ST_DIV1;
                ST_DIV1: begin
                    if (div_done) begin
                        inc_reg   <= div_q;
                        state_reg <= ST_DIV2;
                    end
                end
                ST_DIV2: begin
                    integ_reg <= clamp34(34'(integral_acc_reg) + 34'(inc_reg), out_limit_reg);
                    if (div_done) begin
                        d_reg     <= div_q;
                        state_reg <= ST_DIV3;
                    end
                end
                ST_DIV3: begin
                    if (div_done) begin
                        step_reg  <= div_q[GAIN_W-1:0];
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    sum_reg   <= clamp34(34'(p_reg) + 34'(integ_reg) + 34'(d_reg),
                                         out_limit_reg);
                    state_reg <= ST_RAMP;
                end
                ST_RAMP: begin
                    res_reg   <= sat34(ramp34);
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (res_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        if (clr_reg) begin
                            integral_acc_reg <= '0;
                            last_output_reg  <= '0;
                            last_error_reg   <= '0;
                        end else begin
                            integral_acc_reg <= integ_reg;
                            last_output_reg  <= res_reg;
                            last_error_reg   <= e_reg;
                            last_time_reg    <= now_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV1 || state_reg == ST_DIV2 || state_reg == ST_DIV3))
        else $error("divider finished outside a division state");

    a_control_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && !s_tuser[0]) |=> (state_reg == ST_MUL_P))
        else $error("control request did not start the multiplier sequence");

    a_clear_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_tuser[0]) |=> (res_reg == '0 && state_reg == ST_DONE))
        else $error("clear request did not produce a zero result");

endmodule

// File: rtl/pidrl_mul.sv
module pidrl_mul (
    input  logic        aclk,
    input  logic        en,
    input  logic signed [pidrl_pkg::DATA_W-1:0] a,
    input  logic signed [pidrl_pkg::DATA_W-1:0] b,
    output logic signed [2*pidrl_pkg::DATA_W-1:0] prod_reg
);
    import pidrl_pkg::*;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= a * b;
        end
    end

endmodule

// File: rtl/pidrl_div.sv
module pidrl_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic signed [2*pidrl_pkg::DATA_W-1:0] dividend,
    input  logic [pidrl_pkg::DIV_DEN_W-1:0] divisor,
    output logic        busy_reg,
    output logic        done_reg,
    output logic signed [pidrl_pkg::DATA_W-1:0] quotient
);
    import pidrl_pkg::*;

    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    logic [2*DATA_W-1:0]  mag;
    logic [DIV_DEN_W:0]   rem_w;
    logic [DIV_NUM_W-1:0] num_w;
    logic [DIV_NUM_W-1:0] neg_q;

    assign mag = dividend[2*DATA_W-1] ? 64'(-dividend) : 64'(dividend);

    // Two restoring steps per cycle.
    always_comb begin
        rem_w = {1'b0, rem_reg};
        num_w = num_reg;
        for (int i = 0; i < 2; i++) begin
            rem_w = {rem_w[DIV_DEN_W-1:0], num_w[DIV_NUM_W-1]};
            num_w = {num_w[DIV_NUM_W-2:0], 1'b0};
            if (rem_w >= {1'b0, den_reg}) begin
                rem_w    = rem_w - {1'b0, den_reg};
                num_w[0] = 1'b1;
            end
        end
    end

    assign neg_q = -num_reg;

    always_comb begin
        if (!neg_reg) begin
            quotient = (num_reg > 52'h0_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                        : signed'(num_reg[DATA_W-1:0]);
        end else begin
            quotient = (num_reg > 52'h0_0000_8000_0000) ? 32'sh8000_0000
                                                        : signed'(neg_q[DATA_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= mag[DIV_NUM_W-1:0];
            rem_reg <= '0;
            den_reg <= divisor;
            neg_reg <= dividend[2*DATA_W-1];
        end else if (busy_reg) begin
            num_reg <= num_w;
            rem_reg <= rem_w[DIV_DEN_W-1:0];
        end
    end

endmodule

// File: verif/pid_with_ramp_limit_tb.sv
module pid_with_ramp_limit_tb;

    import pidrl_pkg::*;

    localparam bit OP_STEP  = 1'b0;
    localparam bit OP_CLEAR = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam longint Q16_SCALE      = 65536;
    localparam longint US_PER_SEC     = 1000000;
    localparam longint DT_LIMIT_US    = 500000;
    localparam longint DT_FALLBACK_US = 1000;

    localparam int N_SEGMENTS     = 8;
    localparam int ITEMS_PER_SEG  = 192;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 100;
    localparam int TIMEOUT_CYCLES = 2000000;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic                   op;
        logic [31:0]            word;
        logic [31:0]            ts;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic                   known;
        logic [31:0]            drive;
    } probe_row_t;

    localparam int N_PROBES = 23;

    probe_row_t probe_rows [N_PROBES] = '{
        '{ROW_REQ, OP_STEP,  32'h0000_0000, 32'd1000,      REG_UNUSED,    1'b1, 32'h0},
        '{ROW_REQ, OP_STEP,  32'h0001_0000, 32'd2000,      REG_UNUSED,    1'b0, 32'h0},
        '{ROW_REQ, OP_STEP,  32'h7FFF_FFFF, 32'd2000,      REG_UNUSED,    1'b0, 32'h0},
        '{ROW_REQ, OP_STEP,  32'h8000_0000, 32'd502000,    REG_UNUSED,    1'b0, 32'h0},
        '{ROW_REQ, OP_STEP,  32'hFFFF_0000, 32'd1002001,   REG_UNUSED,    1'b0, 32'h0},
        '{ROW_REQ, OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, REG_UNUSED,    1'b1, 32'h0},
        '{ROW_REQ, OP_STEP,  32'h0005_0000, 32'hFFFF_FF00, REG_UNUSED,    1'b0, 32'h0},
        '{ROW_REQ, OP_STEP,  32'h0005_0000, 32'h0000_0100, REG_UNUSED,    1'b0, 32'h0},
        '{ROW_CFG, OP_STEP,  32'h0001_0000, 32'h0,         REG_GAIN_D,    1'b0, 32'h0},
        '{ROW_REQ, OP_STEP,  32'hFFFB_0000, 32'h0000_0101, REG_UNUSED,    1'b0, 32'h0},
        '{ROW_CFG, OP_STEP,  32'h0000_0000, 32'h0,         REG_RAMP_RATE, 1'b0, 32'h0},
        '{ROW_CFG, OP_STEP,  32'h7FFF_FFFF, 32'h0,         REG_OUT_LIMIT, 1'b0, 32'h0},
        '{ROW_CFG, OP_STEP,  32'h7FFF_FFFF, 32'h0,         REG_GAIN_P,    1'b0, 32'h0},
        '{ROW_REQ, OP_CLEAR, 32'h0000_0000, 32'h0,         REG_UNUSED,    1'b1, 32'h0},
        '{ROW_REQ, OP_STEP,  32'h7FFF_FFFF, 32'h0000_0200, REG_UNUSED,    1'b1, 32'h7FFF_FFFF},
        '{ROW_CFG, OP_STEP,  32'h0001_0000, 32'h0,         REG_OUT_LIMIT, 1'b0, 32'h0},
        '{ROW_CFG, OP_STEP,  32'h0001_0000, 32'h0,         REG_RAMP_RATE, 1'b0, 32'h0},
        '{ROW_REQ, OP_STEP,  32'h0000_0000, 32'h0000_0300, REG_UNUSED,    1'b0, 32'h0},
        '{ROW_CFG, OP_STEP,  32'hFFFF_FFFF, 32'h0,         REG_UNUSED,    1'b0, 32'h0},
        '{ROW_CFG, OP_STEP,  32'hFFFF_FFFF, 32'h0,         REG_GAIN_I,    1'b0, 32'h0},
        '{ROW_REQ, OP_STEP,  32'h8000_0000, 32'h0000_0400, REG_UNUSED,    1'b0, 32'h0},
        '{ROW_CFG, OP_STEP,  32'h0000_0000, 32'h0,         REG_OUT_LIMIT, 1'b0, 32'h0},
        '{ROW_REQ, OP_CLEAR, 32'h0000_0000, 32'h0,         REG_UNUSED,    1'b1, 32'h0}
    };

    int idle_by_phase  [4] = '{0, 46, 0, 19};
    int stall_by_phase [4] = '{0, 0, 46, 19};

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    longint gain_p_q = longint'(RST_GAIN_P);
    longint gain_i_q = longint'(RST_GAIN_I);
    longint gain_d_q = longint'(RST_GAIN_D);
    longint limit_q  = longint'(RST_OUT_LIMIT);
    longint ramp_q   = longint'(RST_RAMP_RATE);

    longint      integ_q = 0;
    longint      out_q   = 0;
    longint      err_q   = 0;
    logic [31:0] time_q  = '0;

    logic [31:0] drive_q [$];
    logic [31:0] want;
    int          fault_count  = 0;
    int          idle_pct     = 0;
    int          stall_pct    = 0;
    int          hold_request = 0;
    int          hold_taken   = 0;
    int          hold_left    = 0;

    pid_with_ramp_limit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint clamp_to_limit(longint v, longint lim);
        if (v > lim) begin
            return lim;
        end
        if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    // Works out the drive for one accepted request and advances the loop state.
    function automatic logic [31:0] predict_drive(bit op, logic [31:0] err_bits,
                                                  logic [31:0] ts);
        logic [31:0] span;
        longint e, dt, p, avg, m, inc, integ, diff, dm, d, drv, step_max;
        if (op == OP_CLEAR) begin
            integ_q = 0;
            out_q   = 0;
            err_q   = 0;
            return '0;
        end
        e    = longint'($signed(err_bits));
        span = ts - time_q;
        dt   = longint'(span);
        if (dt == 0 || dt > DT_LIMIT_US) begin
            dt = DT_FALLBACK_US;
        end
        p     = clip32(gain_p_q * e / Q16_SCALE);
        avg   = clip32((e + err_q) / 2);
        m     = clip32(gain_i_q * avg / Q16_SCALE);
        inc   = clip32(m * dt / US_PER_SEC);
        integ = clamp_to_limit(integ_q + inc, limit_q);
        diff  = clip32(e - err_q);
        dm    = clip32(gain_d_q * diff / Q16_SCALE);
        d     = clip32(dm * US_PER_SEC / dt);
        drv   = clamp_to_limit(p + integ + d, limit_q);
        if (ramp_q != 0) begin
            step_max = ramp_q * dt / US_PER_SEC;
            if (drv - out_q > step_max) begin
                drv = out_q + step_max;
            end else if (drv - out_q < -step_max) begin
                drv = out_q - step_max;
            end
        end
        drv     = clip32(drv);
        integ_q = integ;
        out_q   = drv;
        err_q   = e;
        time_q  = ts;
        return drv[31:0];
    endfunction

    task automatic send_request(bit op, logic [31:0] err_bits, logic [31:0] ts,
                                bit known, logic [31:0] known_drive);
        logic [31:0] predicted;
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ts, err_bits};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        predicted = predict_drive(op, err_bits, ts);
        drive_q.push_back(known ? known_drive : predicted);
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (drive_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_GAIN_P:    gain_p_q = longint'(value[GAIN_W-1:0]);
            REG_GAIN_I:    gain_i_q = longint'(value[GAIN_W-1:0]);
            REG_GAIN_D:    gain_d_q = longint'(value[GAIN_W-1:0]);
            REG_OUT_LIMIT: limit_q  = longint'(value[GAIN_W-1:0]);
            REG_RAMP_RATE: ramp_q   = longint'(value[GAIN_W-1:0]);
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_settings(logic [31:0] gp, logic [31:0] gi, logic [31:0] gd,
                                 logic [31:0] lim, logic [31:0] rr);
        write_setting(REG_GAIN_P, gp);
        write_setting(REG_GAIN_I, gi);
        write_setting(REG_GAIN_D, gd);
        write_setting(REG_OUT_LIMIT, lim);
        write_setting(REG_RAMP_RATE, rr);
    endtask

    task automatic load_segment_settings(int seg);
        logic [31:0] gp, gi, gd, lim, rr;
        gp  = $urandom_range(0, 32'h0004_0000);
        gi  = $urandom_range(0, 32'h0014_0000);
        gd  = $urandom_range(0, 32'h0000_4000);
        lim = $urandom_range(32'h0001_0000, 32'h0064_0000);
        rr  = $urandom_range(32'h0001_0000, 32'h03E8_0000);
        case (seg)
            0: load_settings({1'b0, RST_GAIN_P}, {1'b0, RST_GAIN_I}, {1'b0, RST_GAIN_D},
                             {1'b0, RST_OUT_LIMIT}, {1'b0, RST_RAMP_RATE});
            2: load_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h0);
            // A small limit right after a saturated segment keeps the output
            // slewing back from far outside the limit.
            3: load_settings(gp, gi, gd, 32'h0000_8000, 32'h0010_0000);
            4: load_settings(gp, gi, gd, 32'h0, rr);
            5: load_settings($urandom, $urandom, $urandom, $urandom, $urandom);
            6: load_settings(gp, gi, gd, lim, 32'h0);
            default: load_settings(gp, gi, gd, lim, rr);
        endcase
    endtask

    task automatic issue_random_request();
        bit          op;
        logic [31:0] err_bits, ts;
        int unsigned pick;
        op   = ($urandom_range(99) < 3) ? OP_CLEAR : OP_STEP;
        pick = $urandom_range(99);
        if (pick < 60) begin
            err_bits = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
        end else if (pick < 80) begin
            err_bits = err_q[31:0] + ($urandom_range(0, 32'h3FFF) - 32'h2000);
        end else if (pick < 95) begin
            err_bits = $urandom;
        end else begin
            err_bits = pick[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
        end
        pick = $urandom_range(99);
        if (pick < 80) begin
            ts = time_q + $urandom_range(1, 5000);
        end else if (pick < 88) begin
            ts = time_q;
        end else if (pick < 94) begin
            ts = time_q + $urandom_range(500001, 32'h7FFF_FFFF);
        end else begin
            ts = $urandom;
        end
        send_request(op, err_bits, ts, 1'b0, 32'h0);
    endtask

    // The receiver stalls at random, and for one long stretch on request.
    always @(posedge aclk) begin
        if (hold_taken != hold_request) begin
            hold_taken = hold_request;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (drive_q.size() == 0) begin
                $error("unexpected drive result %0d", $signed(m_tdata));
                fault_count = fault_count + 1;
            end else begin
                want = drive_q.pop_front();
                if (m_tdata !== want) begin
                    $error("drive mismatch: expected %0d, actual %0d",
                           $signed(want), $signed(m_tdata));
                    fault_count = fault_count + 1;
                end
            end
        end
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge aclk);
        $display("pid_with_ramp_limit_tb: done, errors");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (probe_rows[i]) begin
            if (probe_rows[i].kind == ROW_CFG) begin
                quiesce();
                write_setting(probe_rows[i].reg_idx, probe_rows[i].word);
            end else begin
                send_request(probe_rows[i].op, probe_rows[i].word, probe_rows[i].ts,
                             probe_rows[i].known, probe_rows[i].drive);
            end
        end

        for (int seg = 0; seg < N_SEGMENTS; seg++) begin
            quiesce();
            load_segment_settings(seg);
            idle_pct  = idle_by_phase[seg % 4];
            stall_pct = stall_by_phase[seg % 4];
            for (int k = 0; k < ITEMS_PER_SEG; k++) begin
                if (seg == 0 && k == 20) begin
                    hold_request = hold_request + 1;
                end
                issue_random_request();
            end
        end

        quiesce();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fault_count == 0 && drive_q.size() == 0) begin
            $display("pid_with_ramp_limit_tb: done, clean");
        end else begin
            $display("pid_with_ramp_limit_tb: done, errors");
        end
        $finish;
    end

endmodule
